[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Capacity, request codes and the structs passed between the control logic
// and the storage cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 5;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REQ_PRIO   = 2'd0;
  localparam logic [1:0] REQ_TAIL   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Broadcast to every cell for the item being executed.
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic                     at_tail;
    logic signed [DATA_W-1:0] value;
  } spq_cmd_t;

  // Per-cell compare results returned to the control logic.
  typedef struct packed {
    logic gt;
    logic le_tail;
  } spq_stat_t;

endpackage

[rtl/core/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded ordered queue of signed values
// A row of slot cells; an insert shifts or fills the row and a remove pops it
// in the cycle the request is accepted, while the control logic keeps the entry count.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                                   Handshake
// request   in         req_type, value                           start & !busy
// result    out        ok, removed_value, count, is_empty        done (1 cycle)
//
// The cells compare and shift in the cycle an item is accepted, and its result
// shows on the next cycle with done high.
// A new item may be accepted every cycle while busy is low; the compare chain
// across the cells and the shift into the slot registers set this figure.
// busy is high only during reset. Reset clears the count and done; slot
// contents are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic signed [spq_pkg::DATA_W-1:0]   value,
  output logic                                done,
  output logic                                ok,
  output logic signed [spq_pkg::DATA_W-1:0]   removed_value,
  output logic [spq_pkg::OUT_CNT_W-1:0]       count,
  output logic                                is_empty
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] entry_count;
  logic [spq_pkg::CNT_W-1:0] entry_count_next;

  logic accept;
  logic full;
  logic empty;
  logic ok_next;

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat [N];
  logic signed [spq_pkg::DATA_W-1:0] q [N];
  logic [N-1:0] occ;
  logic [N-1:0] le_tail;
  logic [N:0]   found;
  logic [N:0]   placed;

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = (entry_count == spq_pkg::CNT_W'(N));
  assign empty  = (entry_count == '0);

  assign found[0]  = 1'b0;
  assign placed[0] = 1'b0;

  always_comb begin
    cmd.value   = value;
    cmd.ins     = accept && (req_type == spq_pkg::REQ_PRIO || req_type == spq_pkg::REQ_TAIL)
                  && !full;
    cmd.pop     = accept && (req_type == spq_pkg::REQ_REMOVE) && !empty;
    // Tail placement: plain append, empty queue, or a value that is neither
    // above the front nor above the tail.
    cmd.at_tail = (req_type == spq_pkg::REQ_TAIL) || empty
                  || (!stat[0].gt && (|le_tail));
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              occ_prev;
    logic                              occ_next;
    logic signed [spq_pkg::DATA_W-1:0] left;
    logic signed [spq_pkg::DATA_W-1:0] right;

    assign occ[i]     = (spq_pkg::CNT_W'(i) < entry_count);
    assign le_tail[i] = stat[i].le_tail;

    if (i == 0) begin : g_first
      assign occ_prev = 1'b1;
      assign left     = '0;
    end else begin : g_mid
      assign occ_prev = occ[i-1];
      assign left     = q[i-1];
    end

    if (i == N - 1) begin : g_last
      assign occ_next = 1'b0;
      assign right    = '0;
    end else begin : g_inner
      assign occ_next = occ[i+1];
      assign right    = q[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .occ_prev  (occ_prev),
      .occ_next  (occ_next),
      .left      (left),
      .right     (right),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .placed_in (placed[i]),
      .placed_out(placed[i+1]),
      .stat      (stat[i]),
      .q         (q[i])
    );
  end

  always_comb begin
    entry_count_next = entry_count;
    ok_next          = 1'b1;
    unique case (req_type)
      spq_pkg::REQ_PRIO, spq_pkg::REQ_TAIL: begin
        ok_next = !full;
        if (!full) begin
          entry_count_next = entry_count + 1'b1;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        ok_next = !empty;
        if (!empty) begin
          entry_count_next = entry_count - 1'b1;
        end
      end
      default: begin
        entry_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        entry_count <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok            <= ok_next;
      removed_value <= cmd.pop ? q[0] : '0;
      count         <= spq_pkg::OUT_CNT_W'(entry_count_next);
      is_empty      <= (entry_count_next == '0);
    end
  end

endmodule

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one queue slot
// Holds one entry, compares it with the incoming value and takes its next
// content from itself, its left or right neighbor, or the incoming value.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::spq_cmd_t                cmd,
  input  logic                             occ,
  input  logic                             occ_prev,
  input  logic                             occ_next,
  input  logic signed [spq_pkg::DATA_W-1:0] left,
  input  logic signed [spq_pkg::DATA_W-1:0] right,
  input  logic                             found_in,
  output logic                             found_out,
  input  logic                             placed_in,
  output logic                             placed_out,
  output spq_pkg::spq_stat_t               stat,
  output logic signed [spq_pkg::DATA_W-1:0] q
);

  logic gt;
  logic is_last;
  logic here;

  assign gt      = occ && (cmd.value > q);
  assign is_last = occ && !occ_next;

  // In tail mode the slot just past the last entry takes the value;
  // otherwise the first occupied slot holding a smaller value does.
  assign here = cmd.at_tail ? (!occ && occ_prev) : (gt && !found_in);

  assign found_out    = found_in || gt;
  assign placed_out   = placed_in || here;
  assign stat.gt      = gt;
  assign stat.le_tail = is_last && !gt;

  always_ff @(posedge clk) begin
    priority if (cmd.pop) begin
      q <= right;
    end else if (cmd.ins && here) begin
      q <= cmd.value;
    end else if (cmd.ins && placed_in) begin
      q <= left;
    end
  end

endmodule

[rtl/core/spq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the request and result ports and flags results that do not fit
// the accepted items.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              ok,
  input logic signed [spq_pkg::DATA_W-1:0] removed_value,
  input logic [spq_pkg::OUT_CNT_W-1:0]     count,
  input logic                              is_empty
);

  // Every accepted item produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted item gave no result");

  // No result appears without an accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted item");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (removed_value == '0))
    else $error("failed request reported a removed value");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(count) <= spq_pkg::CAPACITY))
    else $error("count above capacity");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .ok           (ok),
  .removed_value(removed_value),
  .count        (count),
  .is_empty     (is_empty)
);
